@@ design/aavr_pkg.sv @@
// shared constants, types and functions for the axis-angle rotation block
`default_nettype none
package aavr_pkg;
	localparam int CordicSteps = 24;
	localparam int IdxW = 5;
	localparam logic signed [35:0] TwoPiQ32 = 36'sd26986075409;
	localparam logic signed [33:0] GainQ30 = 34'sd652032874;
	localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

	// cordic working word, q2.30 with guard bits
	typedef logic signed [33:0] cw_t;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} axis_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	// arctangent table, q2.30
	function automatic cw_t atan_q30(input logic [IdxW-1:0] i);
		case (i)
			5'd0: atan_q30 = 34'sd843314857;
			5'd1: atan_q30 = 34'sd497837829;
			5'd2: atan_q30 = 34'sd263043837;
			5'd3: atan_q30 = 34'sd133525159;
			5'd4: atan_q30 = 34'sd67021687;
			5'd5: atan_q30 = 34'sd33543516;
			5'd6: atan_q30 = 34'sd16775851;
			5'd7: atan_q30 = 34'sd8388437;
			5'd8: atan_q30 = 34'sd4194283;
			5'd9: atan_q30 = 34'sd2097149;
			default: atan_q30 = cw_t'(34'sd1) <<< (30 - i);
		endcase
	endfunction
endpackage
`default_nettype wire

@@ design/aavr_cordic.sv @@
// pipelined sine/cosine cordic, one stage per step
`default_nettype none
module aavr_cordic (
	input wire clk,
	input wire en,
	input wire [15:0] angle,
	output aavr_pkg::cw_t cos_o,
	output aavr_pkg::cw_t sin_o
);
	import aavr_pkg::*;

	cw_t x_s [0:CordicSteps];
	cw_t y_s [0:CordicSteps];
	cw_t z_s [0:CordicSteps];
	logic [1:0] q_s [0:CordicSteps];

	logic [15:0] t;
	logic signed [14:0] r;
	logic signed [51:0] zp;
	assign t = angle + 16'h2000;
	assign r = $signed({1'b0, t[13:0]}) - 15'sd8192;
	assign zp = (52'(r) * 52'(TwoPiQ32) + 52'sd131072) >>> 18;

	// entry stage
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= GainQ30;
			y_s[0] <= '0;
			z_s[0] <= zp[33:0];
			q_s[0] <= t[15:14];
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(IdxW'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(IdxW'(i));
				end
			end
		end
	end

	// quadrant fold
	always_comb begin
		case (q_s[CordicSteps])
			2'd0: begin cos_o = x_s[CordicSteps]; sin_o = y_s[CordicSteps]; end
			2'd1: begin cos_o = -y_s[CordicSteps]; sin_o = x_s[CordicSteps]; end
			2'd2: begin cos_o = -x_s[CordicSteps]; sin_o = -y_s[CordicSteps]; end
			default: begin cos_o = y_s[CordicSteps]; sin_o = -x_s[CordicSteps]; end
		endcase
	end
endmodule
`default_nettype wire

@@ design/aavr_matrix.sv @@
// rodrigues matrix from axis and sine/cosine, three register stages
`default_nettype none
module aavr_matrix (
	input wire clk,
	input wire en,
	input aavr_pkg::axis_t axis,
	input aavr_pkg::cw_t cos_i,
	input aavr_pkg::cw_t sin_i,
	output aavr_pkg::cw_t m [0:8]
);
	import aavr_pkg::*;

	logic signed [32:0] p_s1 [0:5];
	cw_t c_s1, oc_s1, s_s1;
	axis_t a_s1;
	logic signed [35:0] pr_s2 [0:5];
	cw_t sv_s2 [0:2];
	cw_t c_s2;

	function automatic cw_t clampu(input logic signed [35:0] v);
		if (v > 36'(OneQ30)) clampu = OneQ30;
		else if (v < -36'(OneQ30)) clampu = -OneQ30;
		else clampu = v[33:0];
	endfunction

	// axis products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= 33'(axis.ax * axis.ax);
			p_s1[1] <= 33'(axis.ay * axis.ay);
			p_s1[2] <= 33'(axis.az * axis.az);
			p_s1[3] <= 33'(axis.ax * axis.ay);
			p_s1[4] <= 33'(axis.az * axis.ax);
			p_s1[5] <= 33'(axis.ay * axis.az);
			c_s1 <= cos_i;
			oc_s1 <= OneQ30 - cos_i;
			s_s1 <= sin_i;
			a_s1 <= axis;
		end
	end

	// scale by 1-c and sine terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++)
				pr_s2[k] <= 36'((68'(oc_s1) * 68'(p_s1[k]) + 68'sd134217728) >>> 28);
			sv_s2[0] <= 34'((50'(s_s1) * 50'(a_s1.ax) + 50'sd8192) >>> 14);
			sv_s2[1] <= 34'((50'(s_s1) * 50'(a_s1.ay) + 50'sd8192) >>> 14);
			sv_s2[2] <= 34'((50'(s_s1) * 50'(a_s1.az) + 50'sd8192) >>> 14);
			c_s2 <= c_s1;
		end
	end

	// sum and clamp entries
	always_ff @(posedge clk) begin
		if (en) begin
			m[0] <= clampu(36'(c_s2) + pr_s2[0]);
			m[1] <= clampu(pr_s2[3] - 36'(sv_s2[2]));
			m[2] <= clampu(pr_s2[4] + 36'(sv_s2[1]));
			m[3] <= clampu(pr_s2[3] + 36'(sv_s2[2]));
			m[4] <= clampu(36'(c_s2) + pr_s2[1]);
			m[5] <= clampu(pr_s2[5] - 36'(sv_s2[0]));
			m[6] <= clampu(pr_s2[4] - 36'(sv_s2[1]));
			m[7] <= clampu(pr_s2[5] + 36'(sv_s2[0]));
			m[8] <= clampu(36'(c_s2) + pr_s2[2]);
		end
	end
endmodule
`default_nettype wire

@@ design/aavr_apply.sv @@
// matrix times vector with rounding and saturation, two register stages
`default_nettype none
module aavr_apply (
	input wire clk,
	input wire en,
	input aavr_pkg::cw_t m [0:8],
	input aavr_pkg::vec_t v,
	output aavr_pkg::vec_t o
);
	import aavr_pkg::*;

	logic signed [65:0] pp_s1 [0:8];

	function automatic logic signed [31:0] sat(input logic signed [67:0] acc);
		logic signed [67:0] r;
		r = (acc + 68'sd536870912) >>> 30;
		if (r > 68'sd2147483647) sat = 32'h7fffffff;
		else if (r < -68'sd2147483648) sat = 32'h80000000;
		else sat = r[31:0];
	endfunction

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int rw = 0; rw < 3; rw++) begin
				pp_s1[rw*3]   <= 66'(m[rw*3]) * 66'(v.x);
				pp_s1[rw*3+1] <= 66'(m[rw*3+1]) * 66'(v.y);
				pp_s1[rw*3+2] <= 66'(m[rw*3+2]) * 66'(v.z);
			end
		end
	end

	// row sums
	always_ff @(posedge clk) begin
		if (en) begin
			o.x <= sat(68'(pp_s1[0]) + 68'(pp_s1[1]) + 68'(pp_s1[2]));
			o.y <= sat(68'(pp_s1[3]) + 68'(pp_s1[4]) + 68'(pp_s1[5]));
			o.z <= sat(68'(pp_s1[6]) + 68'(pp_s1[7]) + 68'(pp_s1[8]));
		end
	end
endmodule
`default_nettype wire

@@ design/axis_angle_vector_rotation.sv @@
// Axis-angle (Rodrigues) rotation of two 3-D vectors, fully pipelined.
// Input channel: in_valid/in_stall carry axis (Q1.14), angle (turn fraction)
// and two Q16.16 vectors. Output channel: out_valid/out_stall carry both
// rotated vectors, saturated to 32 bits.
// Throughput: one item per cycle while the output is not stalled.
// Pipeline: the 25-stage cordic, three matrix stages and two multiply/sum
// stages lie between acceptance and out_valid; the last multiply/sum stage
// drives the outputs directly.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and in_stall rises, so no item is lost.
// The pipe advances whenever the last stage is empty or being taken;
// empty slots inside the pipe are not squeezed out.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module axis_angle_vector_rotation (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_stall,
	input wire signed [15:0] axis_x,
	input wire signed [15:0] axis_y,
	input wire signed [15:0] axis_z,
	input wire [15:0] angle,
	input wire signed [31:0] first_x,
	input wire signed [31:0] first_y,
	input wire signed [31:0] first_z,
	input wire signed [31:0] second_x,
	input wire signed [31:0] second_y,
	input wire signed [31:0] second_z,
	output logic out_valid,
	input wire out_stall,
	output logic signed [31:0] rotated_first_x,
	output logic signed [31:0] rotated_first_y,
	output logic signed [31:0] rotated_first_z,
	output logic signed [31:0] rotated_second_x,
	output logic signed [31:0] rotated_second_y,
	output logic signed [31:0] rotated_second_z
);
	import aavr_pkg::*;

	localparam int CordLat = CordicSteps + 1;
	localparam int MatLat = 3;
	localparam int Depth = CordLat + MatLat + 2;

	logic en;
	logic [Depth-1:0] vld_q;
	axis_t ax_d [0:CordLat-1];
	vec_t v1_d [0:CordLat+MatLat-1];
	vec_t v2_d [0:CordLat+MatLat-1];
	cw_t c_w, s_w;
	cw_t m_w [0:8];
	vec_t o1_w, o2_w;
	axis_t ax_in;

	// global advance: the final stage is empty or being taken
	assign en = !vld_q[Depth-1] || !out_stall;
	assign in_stall = !en;
	assign out_valid = vld_q[Depth-1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	// delay lines for axis and vectors
	always_ff @(posedge clk) begin
		if (en) begin
			ax_d[0] <= '{ax: axis_x, ay: axis_y, az: axis_z};
			v1_d[0] <= '{x: first_x, y: first_y, z: first_z};
			v2_d[0] <= '{x: second_x, y: second_y, z: second_z};
			for (int k = 1; k < CordLat; k++) ax_d[k] <= ax_d[k-1];
			for (int k = 1; k < CordLat + MatLat; k++) begin
				v1_d[k] <= v1_d[k-1];
				v2_d[k] <= v2_d[k-1];
			end
		end
	end

	aavr_cordic u_cordic (
		.clk(clk), .en(en), .angle(angle),
		.cos_o(c_w), .sin_o(s_w)
	);

	assign ax_in = ax_d[CordLat-1];

	aavr_matrix u_matrix (
		.clk(clk), .en(en), .axis(ax_in), .cos_i(c_w), .sin_i(s_w), .m(m_w)
	);

	aavr_apply u_apply1 (
		.clk(clk), .en(en), .m(m_w), .v(v1_d[CordLat+MatLat-1]), .o(o1_w)
	);

	aavr_apply u_apply2 (
		.clk(clk), .en(en), .m(m_w), .v(v2_d[CordLat+MatLat-1]), .o(o2_w)
	);

	assign rotated_first_x = o1_w.x;
	assign rotated_first_y = o1_w.y;
	assign rotated_first_z = o1_w.z;
	assign rotated_second_x = o2_w.x;
	assign rotated_second_y = o2_w.y;
	assign rotated_second_z = o2_w.z;
endmodule
`default_nettype wire
